// ----- src/image_intensity_centroid_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the intensity centroid block
// Shared concurrent assertion forms on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef IMAGE_INTENSITY_CENTROID_MACROS_SVH
`define IMAGE_INTENSITY_CENTROID_MACROS_SVH

// Property checked only outside reset.
`define ICEN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every edge, reset included.
`define ICEN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/icen_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icen_pkg
// Shared widths, codes and record types of the intensity centroid block.
// ----------------------------------------------------------------------------
package icen_pkg;

  localparam int unsigned DIM_BITS    = 13;
  localparam int unsigned CNT_BITS    = 12;
  localparam int unsigned PIX_BITS    = 24;
  localparam int unsigned PROD_BITS   = CNT_BITS + PIX_BITS;
  localparam int unsigned TOTAL_BITS  = 48;
  localparam int unsigned MOMENT_BITS = 60;
  localparam int unsigned NUM_BITS    = MOMENT_BITS + 2;
  localparam int unsigned DEN_BITS    = TOTAL_BITS + 1;
  localparam int unsigned QUO_BITS    = 17;
  localparam int unsigned TRIAL_BITS  = DEN_BITS + QUO_BITS;
  localparam int unsigned STEP_BITS   = 5;
  localparam int unsigned CTR_BITS    = 16;
  localparam int unsigned FQ_DEPTH    = 2;
  localparam int unsigned OQ_DEPTH    = 2;
  localparam int unsigned LVL_BITS    = 2;
  localparam int unsigned PTR_BITS    = 1;

  localparam logic [DIM_BITS-1:0]  MAX_DIM   = 13'd4096;
  localparam logic [DIM_BITS-1:0]  DIM_RESET = 13'd256;
  localparam logic [STEP_BITS-1:0] STEP_TOP  = 5'd17;
  localparam logic [QUO_BITS-1:0]  POS_LIMIT = 17'd32767;
  localparam logic [QUO_BITS-1:0]  NEG_LIMIT = 17'd32768;
  localparam logic [CTR_BITS-1:0]  CTR_MAX   = 16'h7FFF;
  localparam logic [CTR_BITS-1:0]  CTR_MIN   = 16'h8000;
  localparam logic [CTR_BITS-1:0]  CTR_NONE  = 16'hFFFF;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } icen_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ABS,
    ST_DIVIDE,
    ST_ROUND,
    ST_EMIT
  } icen_state_e;

  typedef struct packed {
    logic signed [TOTAL_BITS-1:0]  total;
    logic signed [MOMENT_BITS-1:0] x_moment;
    logic signed [MOMENT_BITS-1:0] y_moment;
  } icen_frame_t;

  typedef struct packed {
    logic signed [CTR_BITS-1:0] center_x;
    logic signed [CTR_BITS-1:0] center_y;
    logic                       zero_total;
  } icen_result_t;

  typedef struct packed {
    logic                valid;
    logic [LVL_BITS-1:0] level;
  } icen_fq_status_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS-1:0] r;
    if (v == '0) begin
      r = DIM_BITS'(1);
    end else if (v > MAX_DIM) begin
      r = MAX_DIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- src/icen_frame_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icen_frame_fifo
// Two-entry queue of finished frame sums between front and back.
// ----------------------------------------------------------------------------
module icen_frame_fifo import icen_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  icen_frame_t     frame_i,
  input  logic            pop_i,
  output icen_frame_t     frame_o,
  output icen_fq_status_t status_o
);

  icen_frame_t         mem_q [FQ_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [LVL_BITS-1:0] level_q, level_d;
  logic                do_push, do_pop;

  always_comb begin
    do_push  = push_i && (level_q != LVL_BITS'(FQ_DEPTH));
    do_pop   = pop_i && (level_q != '0);
    wr_ptr_d = do_push ? wr_ptr_q + PTR_BITS'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PTR_BITS'(1) : rd_ptr_q;
    level_d  = level_q + LVL_BITS'(do_push) - LVL_BITS'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

  assign frame_o        = mem_q[rd_ptr_q];
  assign status_o.valid = (level_q != '0);
  assign status_o.level = level_q;

endmodule

// ----- src/icen_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icen_front
// Pixel intake: raster counters, moment products and frame accumulators.
// ----------------------------------------------------------------------------
module icen_front import icen_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pixel_push_i,
  input  logic signed [PIX_BITS-1:0] pixel_value_i,
  output logic                       pixel_full_o,
  input  logic [DIM_BITS-1:0]        width_i,
  input  logic [DIM_BITS-1:0]        height_i,
  input  icen_fq_status_t            fq_status_i,
  output logic                       frame_push_o,
  output icen_frame_t                frame_o
);

  logic [CNT_BITS-1:0] col_q, col_d;
  logic [CNT_BITS-1:0] row_q, row_d;
  logic [DIM_BITS-1:0] w_eff, h_eff;
  logic                col_end, row_end, accept, pending;
  logic [LVL_BITS:0]   level_sum;

  logic signed [PROD_BITS:0]   x_prod, y_prod;
  logic                        s1_valid_q, s1_last_q;
  logic signed [PIX_BITS-1:0]  s1_pix_q;
  logic signed [PROD_BITS-1:0] s1_xp_q, s1_yp_q;

  logic signed [TOTAL_BITS-1:0]  total_q, total_sum;
  logic signed [MOMENT_BITS-1:0] xm_q, xm_sum, ym_q, ym_sum;

  always_comb begin
    w_eff     = clamp_dim(width_i);
    h_eff     = clamp_dim(height_i);
    col_end   = (DIM_BITS'(col_q) + DIM_BITS'(1)) >= w_eff;
    row_end   = (DIM_BITS'(row_q) + DIM_BITS'(1)) >= h_eff;
    // A last pixel in stage one still owes the queue an entry.
    pending   = s1_valid_q && s1_last_q;
    level_sum = {1'b0, fq_status_i.level} + (LVL_BITS + 1)'(pending);
    pixel_full_o = level_sum >= (LVL_BITS + 1)'(FQ_DEPTH);
    accept    = pixel_push_i && !pixel_full_o;

    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + CNT_BITS'(1);
      end else begin
        col_d = col_q + CNT_BITS'(1);
      end
    end

    x_prod = $signed({1'b0, col_q}) * pixel_value_i;
    y_prod = $signed({1'b0, row_q}) * pixel_value_i;

    total_sum = total_q + TOTAL_BITS'(s1_pix_q);
    xm_sum    = xm_q + MOMENT_BITS'(s1_xp_q);
    ym_sum    = ym_q + MOMENT_BITS'(s1_yp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      total_q    <= '0;
      xm_q       <= '0;
      ym_q       <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept;
      s1_last_q  <= col_end && row_end;
      if (s1_valid_q) begin
        // Clear on the frame's last pixel, its sums leave through the queue.
        total_q <= s1_last_q ? '0 : total_sum;
        xm_q    <= s1_last_q ? '0 : xm_sum;
        ym_q    <= s1_last_q ? '0 : ym_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= pixel_value_i;
      s1_xp_q  <= x_prod[PROD_BITS-1:0];
      s1_yp_q  <= y_prod[PROD_BITS-1:0];
    end
  end

  assign frame_push_o     = s1_valid_q && s1_last_q;
  assign frame_o.total    = total_sum;
  assign frame_o.x_moment = xm_sum;
  assign frame_o.y_moment = ym_sum;

endmodule

// ----- src/icen_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icen_back
// Per-frame rounding divider, saturation and two-entry result queue.
// ----------------------------------------------------------------------------
module icen_back import icen_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  icen_fq_status_t            fq_status_i,
  input  icen_frame_t                frame_i,
  output logic                       frame_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic signed [CTR_BITS-1:0] center_x_o,
  output logic signed [CTR_BITS-1:0] center_y_o,
  output logic                       zero_total_o
);

  icen_state_e state_q, state_d;

  logic                         axis_q, axis_d;
  logic                         tot_neg_q, tot_neg_d;
  logic                         zero_q, zero_d;
  logic                         neg_q, neg_d;
  logic                         ovf_q, ovf_d;
  logic [DEN_BITS-1:0]          den_q, den_d;
  logic signed [NUM_BITS-1:0]   num_q, num_d;
  logic [NUM_BITS-1:0]          rem_q, rem_d;
  logic [QUO_BITS-1:0]          quo_q, quo_d;
  logic [STEP_BITS-1:0]         step_q, step_d;
  logic [CTR_BITS-1:0]          cx_q, cx_d, cy_q, cy_d;

  logic [TOTAL_BITS-1:0]        tot_abs;
  logic signed [MOMENT_BITS-1:0] mom;
  logic [TRIAL_BITS-1:0]        shifted, rem_ext, diff;
  logic                         ge;
  logic [QUO_BITS-1:0]          neg_mag;
  logic [CTR_BITS-1:0]          sat;

  icen_result_t        oq_q [OQ_DEPTH];
  icen_result_t        oq_entry;
  logic [PTR_BITS-1:0] oq_wr_q, oq_rd_q;
  logic [LVL_BITS-1:0] oq_level_q;
  logic                oq_push, oq_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    tot_neg_d = tot_neg_q;
    zero_d    = zero_q;
    neg_d     = neg_q;
    ovf_d     = ovf_q;
    den_d     = den_q;
    num_d     = num_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    step_d    = step_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    frame_pop_o = 1'b0;
    oq_push     = 1'b0;

    tot_abs = frame_i.total[TOTAL_BITS-1] ? TOTAL_BITS'(-frame_i.total)
                                          : TOTAL_BITS'(frame_i.total);
    mom     = axis_q ? frame_i.y_moment : frame_i.x_moment;
    shifted = TRIAL_BITS'(den_q) << step_q;
    rem_ext = TRIAL_BITS'(rem_q);
    ge      = rem_ext >= shifted;
    diff    = rem_ext - shifted;
    neg_mag = QUO_BITS'(0) - quo_q;
    if (!neg_q) begin
      sat = (ovf_q || (quo_q > POS_LIMIT)) ? CTR_MAX : quo_q[CTR_BITS-1:0];
    end else begin
      sat = (ovf_q || (quo_q > NEG_LIMIT)) ? CTR_MIN : neg_mag[CTR_BITS-1:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (fq_status_i.valid) begin
          den_d     = {tot_abs, 1'b0};
          tot_neg_d = frame_i.total[TOTAL_BITS-1];
          axis_d    = 1'b0;
          if (frame_i.total == '0) begin
            zero_d  = 1'b1;
            cx_d    = CTR_NONE;
            cy_d    = CTR_NONE;
            state_d = ST_EMIT;
          end else begin
            zero_d  = 1'b0;
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        // Rounded quotient: (2*moment + total) / (2*total).
        num_d   = (NUM_BITS'(mom) <<< 1) + NUM_BITS'(frame_i.total);
        state_d = ST_ABS;
      end
      ST_ABS: begin
        neg_d   = num_q[NUM_BITS-1] ^ tot_neg_q;
        rem_d   = num_q[NUM_BITS-1] ? NUM_BITS'(-num_q) : NUM_BITS'(num_q);
        quo_d   = '0;
        ovf_d   = 1'b0;
        step_d  = STEP_TOP;
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        // Top step only detects a quotient too large for the result.
        if (step_q == STEP_TOP) begin
          ovf_d = ge;
        end else if (ge) begin
          rem_d = diff[NUM_BITS-1:0];
          quo_d = quo_q | (QUO_BITS'(1) << step_q);
        end
        if (step_q == '0) begin
          state_d = ST_ROUND;
        end else begin
          step_d = step_q - STEP_BITS'(1);
        end
      end
      ST_ROUND: begin
        if (!axis_q) begin
          cx_d    = sat;
          axis_d  = 1'b1;
          state_d = ST_SETUP;
        end else begin
          cy_d    = sat;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (oq_level_q != LVL_BITS'(OQ_DEPTH)) begin
          oq_push     = 1'b1;
          frame_pop_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    axis_q    <= axis_d;
    tot_neg_q <= tot_neg_d;
    zero_q    <= zero_d;
    neg_q     <= neg_d;
    ovf_q     <= ovf_d;
    den_q     <= den_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    step_q    <= step_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
  end

  // Result queue
  assign oq_pop              = pop_i && (oq_level_q != '0);
  assign oq_entry.center_x   = cx_q;
  assign oq_entry.center_y   = cy_q;
  assign oq_entry.zero_total = zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q    <= '0;
      oq_rd_q    <= '0;
      oq_level_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + PTR_BITS'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + PTR_BITS'(1);
      end
      oq_level_q <= oq_level_q + LVL_BITS'(oq_push) - LVL_BITS'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wr_q] <= oq_entry;
    end
  end

  assign empty_o      = (oq_level_q == '0);
  assign center_x_o   = oq_q[oq_rd_q].center_x;
  assign center_y_o   = oq_q[oq_rd_q].center_y;
  assign zero_total_o = oq_q[oq_rd_q].zero_total;

endmodule

// ----- src/image_intensity_centroid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_intensity_centroid
// Intensity-weighted centroid of a frame of signed pixels, one result/frame.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter through a queue-style port: drive pixel_value_i with push;
//   a transaction takes place on a clock edge with push high and full low.
//   Pixels arrive in raster order, column fastest; frame size comes from the
//   width and height registers (cfg_index_i 0 and 1). Zero acts as one and
//   values above 4096 act as 4096.
//   Throughput: one pixel per cycle while full is low. A zero-total frame
//   skips the divide; full rises when two finished frames wait, or one waits
//   and the next frame's last pixel is in the intake stage, so with results
//   drained only frames shorter than the divider's run per frame see it.
//   Path: with the divider free, the result of a frame shows (empty low)
//   after these steps: its last pixel passes one intake stage into the frame
//   queue, the divider starts the frame, then per axis one sum, one absolute
//   value, 18 restoring divide steps and one saturation step in a single
//   shared divider, then a write into the result queue.
//   Results: while empty is low the oldest result sits on center_x_o,
//   center_y_o and zero_total_o; pop takes it. A stalled reader holds it;
//   the divider then waits and, once the frame queue fills, full stops input.
//   Reset: all counters, sums and queues clear; both registers return to 256.
// ----------------------------------------------------------------------------
module image_intensity_centroid import icen_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic signed [PIX_BITS-1:0] pixel_value_i,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [CTR_BITS-1:0] center_x_o,
  output logic signed [CTR_BITS-1:0] center_y_o,
  output logic                       zero_total_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [DIM_BITS-1:0]        cfg_data_i
);

  logic [DIM_BITS-1:0] width_q, height_q;
  icen_fq_status_t     fq_status;
  icen_frame_t         front_frame, head_frame;
  logic                frame_push, frame_pop;

  // Configuration registers: take the write at once, no handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (icen_reg_e'(cfg_index_i))
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: begin
          width_q <= width_q;
        end
      endcase
    end
  end

  // Front: count columns and rows, accumulate sums, hand off each frame.
  icen_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_push_i  (push),
    .pixel_value_i (pixel_value_i),
    .pixel_full_o  (full),
    .width_i       (width_q),
    .height_i      (height_q),
    .fq_status_i   (fq_status),
    .frame_push_o  (frame_push),
    .frame_o       (front_frame)
  );

  // Frame queue decouples pixel intake from the per-frame divide.
  icen_frame_fifo u_frame_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (frame_push),
    .frame_i  (front_frame),
    .pop_i    (frame_pop),
    .frame_o  (head_frame),
    .status_o (fq_status)
  );

  // Back: divide, round, saturate, queue the result.
  icen_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fq_status_i  (fq_status),
    .frame_i      (head_frame),
    .frame_pop_o  (frame_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .center_x_o   (center_x_o),
    .center_y_o   (center_y_o),
    .zero_total_o (zero_total_o)
  );

endmodule

// ----- src/icen_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icen_checker
// Port-level checks of the centroid block, bound to the top level.
// ----------------------------------------------------------------------------
`include "image_intensity_centroid_macros.svh"

module icen_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] center_x_o,
  input logic [15:0] center_y_o,
  input logic        zero_total_o
);

  property p_hold_result;
    !empty && !pop |=> !empty && $stable(center_x_o) && $stable(center_y_o)
                       && $stable(zero_total_o);
  endproperty

  property p_zero_center;
    !empty && zero_total_o |-> center_x_o == 16'hFFFF && center_y_o == 16'hFFFF;
  endproperty

  // Nothing waits in either queue while reset is applied.
  `ICEN_ASSERT_RST(a_reset_clear, !rst_ni |-> empty && !full, "queues not clear in reset")

  // A waiting result is held until popped.
  `ICEN_ASSERT(a_hold_result, p_hold_result, "result changed while waiting")

  // A zero-sum frame reports both centers as minus one.
  `ICEN_ASSERT(a_zero_center, p_zero_center, "zero total without minus one centers")

  // Backpressure can only start right after a pixel was offered.
  `ICEN_ASSERT(a_full_cause, $rose(full) |-> $past(push), "full rose without input")

endmodule

bind image_intensity_centroid icen_checker u_icen_checker (.*);

// ----- tb/sv/tb_image_intensity_centroid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_intensity_centroid
// Self-checking bench for the intensity-weighted centroid block.
// Drives frames of signed pixels through the push/full port and pops results
// through the empty/pop port. A built-in frame accumulator predicts every
// centroid, and a monitor checks each popped result field by field. The run
// covers mid-frame resizing, saturation, zero totals, clamped dimensions,
// the widest and tallest register settings and random traffic with random
// back-pressure.
// ----------------------------------------------------------------------------
module tb_image_intensity_centroid import icen_pkg::*; ();

  localparam int unsigned  RANDOM_ITEMS   = 400;
  localparam int unsigned  LONG_RUN       = 80;
  localparam int unsigned  SETTLE_CYCLES  = 64;
  localparam int unsigned  LIMIT_CYCLES   = 1_500_000;
  localparam longint       CENTER_MAX     = 32767;
  localparam longint       CENTER_MIN     = -32768;

  typedef enum logic [1:0] {
    DRAIN_STEADY,
    DRAIN_COIN,
    DRAIN_SPARSE
  } drain_mode_e;

  // DUT ports; reset is driven low at time zero so the reset edge is seen.
  logic                       clk_i         = 1'b0;
  logic                       rst_ni;
  logic                       push          = 1'b0;
  logic                       full;
  logic signed [PIX_BITS-1:0] pixel_value_i = '0;
  logic                       empty;
  logic                       pop           = 1'b0;
  logic signed [CTR_BITS-1:0] center_x_o;
  logic signed [CTR_BITS-1:0] center_y_o;
  logic                       zero_total_o;
  logic                       cfg_we_i      = 1'b0;
  logic                       cfg_index_i   = REG_WIDTH;
  logic [DIM_BITS-1:0]        cfg_data_i    = '0;

  // Shadow of the frame accumulator: registers, counters and sums.
  logic [DIM_BITS-1:0]           width_reg  = DIM_RESET;
  logic [DIM_BITS-1:0]           height_reg = DIM_RESET;
  int unsigned                   col_idx    = 0;
  int unsigned                   row_idx    = 0;
  logic signed [TOTAL_BITS-1:0]  sum_total  = '0;
  logic signed [MOMENT_BITS-1:0] sum_x      = '0;
  logic signed [MOMENT_BITS-1:0] sum_y      = '0;

  // Centroids predicted but not yet popped, oldest first.
  icen_result_t centroid_q[$];

  int unsigned  mismatch_count = 0;
  int unsigned  burst_left     = 0;
  int unsigned  cycle_count    = 0;
  drain_mode_e  drain_mode     = DRAIN_STEADY;
  int unsigned  drain_left     = 0;

  image_intensity_centroid dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .pixel_value_i(pixel_value_i),
    .empty        (empty),
    .pop          (pop),
    .center_x_o   (center_x_o),
    .center_y_o   (center_y_o),
    .zero_total_o (zero_total_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Zero acts as one; anything past the largest frame acts as the largest.
  function automatic int unsigned effective_dim(input logic [DIM_BITS-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Round moment/total half up, truncate toward zero, saturate to 16 bits.
  // Done as trunc((2*moment + total) / (2*total)) to stay exact.
  function automatic logic [CTR_BITS-1:0] rounded_center(input longint moment,
                                                         input longint total);
    longint num;
    longint den;
    longint quo;
    num = 2 * moment + total;
    den = 2 * total;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    quo = num / den;
    if (quo > CENTER_MAX) begin
      quo = CENTER_MAX;
    end else if (quo < CENTER_MIN) begin
      quo = CENTER_MIN;
    end
    return CTR_BITS'(quo);
  endfunction

  // Fold one accepted pixel into the sums; queue a centroid on the last pixel.
  function automatic void accumulate_pixel(input logic signed [PIX_BITS-1:0] value);
    longint       pix;
    longint       total;
    icen_result_t res;
    pix       = value;
    sum_total = TOTAL_BITS'(longint'(sum_total) + pix);
    sum_x     = MOMENT_BITS'(longint'(sum_x) + longint'(col_idx) * pix);
    sum_y     = MOMENT_BITS'(longint'(sum_y) + longint'(row_idx) * pix);
    // Counters survive a resize: a column or row past the new last index
    // wraps at this pixel.
    if (col_idx + 1 < effective_dim(width_reg)) begin
      col_idx++;
      return;
    end
    col_idx = 0;
    if (row_idx + 1 < effective_dim(height_reg)) begin
      row_idx++;
      return;
    end
    row_idx = 0;
    total   = sum_total;
    if (total == 0) begin
      res.center_x   = CTR_NONE;
      res.center_y   = CTR_NONE;
      res.zero_total = 1'b1;
    end else begin
      res.center_x   = rounded_center(sum_x, total);
      res.center_y   = rounded_center(sum_y, total);
      res.zero_total = 1'b0;
    end
    centroid_q.push_back(res);
    sum_total = '0;
    sum_x     = '0;
    sum_y     = '0;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // --------------------------------------------------------------------------

  // Switch between steady draining, coin-flip pops and rare pops at random
  // intervals so back-pressure fills the result queue, stalls the divider and reaches full.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (drain_left == 0) begin
        drain_mode = drain_mode_e'($urandom_range(0, 2));
        drain_left = $urandom_range(30, 200);
      end else begin
        drain_left--;
      end
      case (drain_mode)
        DRAIN_STEADY: pop <= 1'b1;
        DRAIN_COIN:   pop <= 1'($urandom_range(0, 1));
        default:      pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Compare each popped transaction against the oldest predicted centroid.
  always @(posedge clk_i) begin
    icen_result_t want;
    if (rst_ni && pop && !empty) begin
      if (centroid_q.size() == 0) begin
        $error("unexpected result: center_x=%0d center_y=%0d zero_total=%0b",
               center_x_o, center_y_o, zero_total_o);
        mismatch_count++;
      end else begin
        want = centroid_q.pop_front();
        if (center_x_o !== want.center_x) begin
          $error("center_x: expected %0d, got %0d", want.center_x, center_x_o);
          mismatch_count++;
        end
        if (center_y_o !== want.center_y) begin
          $error("center_y: expected %0d, got %0d", want.center_y, center_y_o);
          mismatch_count++;
        end
        if (zero_total_o !== want.zero_total) begin
          $error("zero_total: expected %0b, got %0b", want.zero_total, zero_total_o);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pixel side
  // --------------------------------------------------------------------------

  // Send one pixel. Push stays high across a burst; between bursts drop it
  // for a random gap. The transaction lands at the first edge with full low.
  task automatic send_pixel(input logic signed [PIX_BITS-1:0] value);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    push          <= 1'b1;
    pixel_value_i <= value;
    do @(posedge clk_i); while (full);
    accumulate_pixel(value);
  endtask

  // Hold input off until every predicted centroid is popped, then let the
  // intake and divider drain so a register write cannot race a pixel.
  task automatic settle();
    push <= 1'b0;
    while (centroid_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the width register, then the height register; write enable stays
  // high across the pair.
  task automatic write_dims(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= REG_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    width_reg   = w;
    height_reg  = h;
  endtask

  // Mix of full-range noise, tiny values that often cancel, bright positive
  // pixels and the field extremes.
  function automatic logic signed [PIX_BITS-1:0] random_pixel();
    case ($urandom_range(0, 3))
      0: return PIX_BITS'($urandom);
      1: return PIX_BITS'(int'($urandom_range(0, 8)) - 4);
      2: return PIX_BITS'($urandom_range(0, 8388607));
      default: begin
        case ($urandom_range(0, 3))
          0: return 24'sh7FFFFF;
          1: return 24'sh800000;
          2: return 24'sh000000;
          default: return 24'shFFFFFF;
        endcase
      end
    endcase
  endfunction

  // Mostly small frames; now and then zero, exactly the maximum, or a value
  // past the maximum so partial frames get cut by the next resize.
  function automatic logic [DIM_BITS-1:0] random_dim(input int unsigned typical_max);
    case ($urandom_range(0, 19))
      0: return '0;
      1: return DIM_BITS'($urandom_range(4097, 8191));
      2: return MAX_DIM;
      default: return DIM_BITS'($urandom_range(1, typical_max));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Start under the reset size, then shrink mid-frame: the column past the
  // new width wraps its row at the next pixel, and the row past the new
  // height closes the frame.
  task automatic test_resize_mid_frame();
    send_pixel(24'sd100);
    send_pixel(24'sd200);
    send_pixel(24'sd300);
    settle();
    write_dims(13'd2, DIM_RESET);
    send_pixel(24'sd400);
    send_pixel(24'sd500);
    settle();
    write_dims(13'd2, 13'd1);
    send_pixel(24'sd600);
  endtask

  // Two-pixel rows: near-cancelling extremes push the centroid far out of
  // 16-bit range both ways; also a zero total, half-way ties and the most
  // negative total.
  task automatic test_saturation_and_zero_total();
    settle();
    write_dims(13'd2, 13'd1);
    send_pixel(-24'sd8388606);
    send_pixel(24'sd8388607);
    send_pixel(24'sd8388607);
    send_pixel(-24'sd8388606);
    send_pixel(24'sd5);
    send_pixel(-24'sd5);
    send_pixel(24'sd1);
    send_pixel(24'sd1);
    send_pixel(-24'sd3);
    send_pixel(24'sd1);
    send_pixel(24'sh800000);
    send_pixel(24'sh800000);
    send_pixel(24'sh7FFFFF);
    send_pixel(24'sh7FFFFF);
  endtask

  // Zero in both registers acts as a 1x1 frame: one result per pixel.
  task automatic test_clamped_dims();
    settle();
    write_dims('0, '0);
    send_pixel(24'sd0);
    send_pixel(24'sh7FFFFF);
    send_pixel(24'sh800000);
  endtask

  // Widest and tallest settings: a long run into a full-width row (width
  // written as all ones, clamped), closed by shrinking to 1x1; then the same
  // down a full-height column.
  task automatic test_extreme_dims();
    settle();
    write_dims(13'h1FFF, 13'd1);
    repeat (LONG_RUN) send_pixel(random_pixel());
    settle();
    write_dims(13'd1, 13'd1);
    send_pixel(random_pixel());
    settle();
    write_dims(13'd1, MAX_DIM);
    repeat (LONG_RUN) send_pixel(random_pixel());
    settle();
    write_dims(13'd1, 13'd1);
    send_pixel(random_pixel());
  endtask

  // Random phases: new dimensions, then a random run of pixels. Keep going
  // until enough pixels have gone through.
  task automatic test_random_traffic();
    int unsigned items;
    int unsigned phase_len;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      settle();
      write_dims(random_dim(8), random_dim(6));
      phase_len = $urandom_range(10, 60);
      repeat (phase_len) send_pixel(random_pixel());
      items += phase_len;
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_resize_mid_frame();
    test_saturation_and_zero_total();
    test_clamped_dims();
    test_extreme_dims();
    test_random_traffic();

    // Drain every outstanding centroid plus the pipeline tail.
    settle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
